[rtl/sharp_pkg.sv]
package sharp_pkg;

    // Component and field widths
    localparam int PIX_W      = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int IDX_OUT_W  = 13;
    localparam int ROW_CNT_W  = 13;   // wide enough for any height register value
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CH_W       = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 12;   // signed range -1020..1275
    localparam int OUT_DATA_W = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    // Reset values
    localparam logic [WIDTH_W-1:0]  RST_WIDTH    = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT   = 13'd480;
    localparam logic [CH_W-1:0]     RST_CHANNELS = 3'd3;

    localparam int CENTRE_GAIN = 5;
    localparam int PIX_MAX     = 255;

    typedef struct packed {
        logic                 last;
        logic [PIX_W-1:0]     value;
        logic [IDX_OUT_W-1:0] index;
        logic [ROW_OUT_W-1:0] row;
    } t_result;

endpackage

[rtl/sharp_cfg.sv]
module sharp_cfg #(
    parameter  int MAX_WIDTH    = 2048,
    parameter  int MAX_HEIGHT   = 4096,
    parameter  int MAX_CHANNELS = 4,
    localparam int DEPTH        = MAX_WIDTH * MAX_CHANNELS,
    localparam int LEN_W        = $clog2(DEPTH + 1),
    localparam int HE_W         = ($clog2(MAX_HEIGHT + 1) > 13) ? $clog2(MAX_HEIGHT + 1) : 13
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sharp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sharp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [sharp_pkg::CH_W-1:0]       o_chan,
    output logic [LEN_W-1:0]                 o_len,
    output logic [HE_W-1:0]                  o_h_last
);
    import sharp_pkg::*;

    localparam int WE_W = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CH_W-1:0]     r_chan;

    logic [WE_W-1:0]      w_eff;
    logic [HE_W-1:0]      h_eff;
    logic [CH_W-1:0]      c_eff;
    logic [WE_W+CH_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_chan   <= RST_CHANNELS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:    r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT:   r_height <= i_cfg_data[HEIGHT_W-1:0];
                REG_CHANNELS: r_chan   <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range values are clamped where used
    always_comb begin
        if (WE_W'(r_width) < WE_W'(3))
            w_eff = WE_W'(3);
        else if (WE_W'(r_width) > WE_W'(MAX_WIDTH))
            w_eff = WE_W'(MAX_WIDTH);
        else
            w_eff = WE_W'(r_width);

        if (HE_W'(r_height) < HE_W'(3))
            h_eff = HE_W'(3);
        else if (HE_W'(r_height) > HE_W'(MAX_HEIGHT))
            h_eff = HE_W'(MAX_HEIGHT);
        else
            h_eff = HE_W'(r_height);

        if (r_chan == '0)
            c_eff = CH_W'(1);
        else if (r_chan > CH_W'(MAX_CHANNELS))
            c_eff = CH_W'(MAX_CHANNELS);
        else
            c_eff = r_chan;

        prod = (WE_W+CH_W)'(w_eff) * (WE_W+CH_W)'(c_eff);
    end

    assign o_chan   = c_eff;
    assign o_len    = LEN_W'(prod);
    assign o_h_last = h_eff - HE_W'(1);

endmodule

[rtl/sharp_line.sv]
module sharp_line #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_addr,
    input  logic [AW-1:0]                i_addr_right,
    input  logic [sharp_pkg::PIX_W-1:0]  i_sample,
    input  logic                         i_older_we,
    input  logic [AW-1:0]                i_older_addr,
    input  logic [sharp_pkg::PIX_W-1:0]  i_older_data,
    output logic [sharp_pkg::PIX_W-1:0]  o_centre,
    output logic [sharp_pkg::PIX_W-1:0]  o_right,
    output logic [sharp_pkg::PIX_W-1:0]  o_up
);
    import sharp_pkg::*;

    // newer line: row r-1 being overwritten by row r
    // older line: row r-2 being overwritten by row r-1
    logic [PIX_W-1:0] r_newer [DEPTH];
    logic [PIX_W-1:0] r_older [DEPTH];

    // Reads return the value before a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_centre       <= r_newer[i_addr];
            o_right        <= r_newer[i_addr_right];
            r_newer[i_addr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            o_up <= r_older[i_addr];
        if (i_older_we)
            r_older[i_older_addr] <= i_older_data;
    end

endmodule

[rtl/sharp_calc.sv]
module sharp_calc (
    input  logic [sharp_pkg::PIX_W-1:0] i_centre,
    input  logic [sharp_pkg::PIX_W-1:0] i_up,
    input  logic [sharp_pkg::PIX_W-1:0] i_down,
    input  logic [sharp_pkg::PIX_W-1:0] i_left,
    input  logic [sharp_pkg::PIX_W-1:0] i_right,
    output logic [sharp_pkg::PIX_W-1:0] o_value
);
    import sharp_pkg::*;

    logic [SUM_W-1:0]        pos;
    logic [SUM_W-1:0]        neg;
    logic signed [SUM_W-1:0] diff;

    always_comb begin
        pos  = SUM_W'(CENTRE_GAIN) * SUM_W'(i_centre);
        neg  = SUM_W'(i_up) + SUM_W'(i_down) + SUM_W'(i_left) + SUM_W'(i_right);
        diff = $signed(pos - neg);
        if (diff < 0)
            o_value = '0;
        else if (diff > SUM_W'(PIX_MAX))
            o_value = PIX_W'(PIX_MAX);
        else
            o_value = diff[PIX_W-1:0];
    end

endmodule

[rtl/sharpen_3x3_stencil_core.sv]
// 3x3 Laplacian sharpen over a raster stream of 8-bit components with the
// channels of each pixel interleaved. Each result is 5*centre minus the
// up, down, left and right neighbours of the same channel, clamped to
// 0..255; the first and last rows and pixel columns give zero. The result
// for row r-1, component i comes out for the input at row r, component i;
// no result comes out during row 0, and every input of the last row gives
// two results: (r-1, i) first, then the zero border (r, i) with tlast set.
// Otherwise tlast is set on the single result of an input.
// Throughput: one component per clock while the master side is ready; in
// the last row each input gives two results, and the next one waits while
// the border result is held in r_p. Two line buffers, each of
// MAX_WIDTH*MAX_CHANNELS bytes, hold the previous two rows; the newer one
// is read at the centre and right-neighbour addresses for each accepted
// sample. Line buffers are not cleared after reset and need no clearing
// pass. Configuration (width, height, channels) is to be written through
// the cfg port only between frames while the block is idle; the block
// itself does not enforce this. Out-of-range values are clamped.
module sharpen_3x3_stencil_core #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_HEIGHT   = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sharp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sharp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,   // [7:0] sample
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [11:0] out_row, [24:12] out_index, [32:25] value, [39:33] zero
    output logic [sharp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast    // last_of_run
);
    import sharp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int HE_W  = ($clog2(MAX_HEIGHT + 1) > 13) ? $clog2(MAX_HEIGHT + 1) : 13;

    // ---------------- geometry ----------------
    logic [CH_W-1:0]  chan;
    logic [LEN_W-1:0] len;
    logic [HE_W-1:0]  h_last;

    sharp_cfg #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_chan    (chan),
        .o_len     (len),
        .o_h_last  (h_last)
    );

    // ---------------- stage A: position counters ----------------
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [ROW_CNT_W-1:0] r_row, n_row;
    logic                 accept;
    logic [LEN_W-1:0]     idx_l;
    logic [LEN_W-1:0]     chan_l;
    logic                 end_row;
    logic                 last_row;
    logic                 interior;
    logic [IDX_W-1:0]     addr_right;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        idx_l    = LEN_W'(r_idx);
        chan_l   = LEN_W'(chan);
        end_row  = idx_l >= (len - LEN_W'(1));
        last_row = HE_W'(r_row) >= h_last;
        // rows 1..h-2 of the result, component columns c..len-c-1
        interior = (r_row >= ROW_CNT_W'(2)) && (HE_W'(r_row) <= h_last) &&
                   (idx_l >= chan_l) && (idx_l < (len - chan_l));
        addr_right = IDX_W'(idx_l + chan_l);

        n_idx = r_idx;
        n_row = r_row;
        if (accept) begin
            if (end_row) begin
                n_idx = '0;
                n_row = last_row ? '0 : r_row + ROW_CNT_W'(1);
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_row <= '0;
        end else begin
            r_idx <= n_idx;
            r_row <= n_row;
        end
    end

    // ---------------- stage B: neighbourhood and arithmetic ----------------
    logic                 r_b_valid;
    logic [IDX_W-1:0]     r_b_idx;
    logic [ROW_CNT_W-1:0] r_b_row;
    logic [PIX_W-1:0]     r_b_sample;
    logic                 r_b_last_row;
    logic                 r_b_interior;
    logic                 b_has_res;
    logic                 b_go;
    logic                 out_free;

    logic [PIX_W-1:0] centre, right, up, left, kern_value;
    logic [PIX_W-1:0] r_hist [MAX_CHANNELS];

    sharp_line #(
        .DEPTH(DEPTH),
        .AW   (IDX_W)
    ) u_line (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_addr      (r_idx),
        .i_addr_right(addr_right),
        .i_sample    (i_s_axis_tdata[PIX_W-1:0]),
        .i_older_we  (b_go),
        .i_older_addr(r_b_idx),
        .i_older_data(centre),
        .o_centre    (centre),
        .o_right     (right),
        .o_up        (up)
    );

    // Left neighbour is the centre read c items earlier (row r-1, index i-c)
    always_comb begin
        left = r_hist[0];
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (chan == CH_W'(k + 1))
                left = r_hist[k];
        end
    end

    sharp_calc u_calc (
        .i_centre(centre),
        .i_up    (up),
        .i_down  (r_b_sample),
        .i_left  (left),
        .i_right (right),
        .o_value (kern_value)
    );

    // ---------------- output buffer ----------------
    // r_o is the result on the port; r_p holds the border result of the
    // last row that must follow it.
    logic    r_ov, r_pv;
    t_result r_o, r_p;
    t_result res_first, res_second;

    assign b_has_res = (r_b_row != '0);
    assign out_free  = !r_ov || (i_m_axis_tready && !r_pv);
    assign b_go      = r_b_valid && (!b_has_res || out_free);
    assign o_s_axis_tready = !r_b_valid || b_go;

    always_comb begin
        res_first.row    = ROW_OUT_W'(r_b_row - ROW_CNT_W'(1));
        res_first.index  = IDX_OUT_W'(r_b_idx);
        res_first.value  = r_b_interior ? kern_value : '0;
        res_first.last   = !r_b_last_row;
        res_second.row   = ROW_OUT_W'(r_b_row);
        res_second.index = IDX_OUT_W'(r_b_idx);
        res_second.value = '0;
        res_second.last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_ov      <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            if (accept)
                r_b_valid <= 1'b1;
            else if (b_go)
                r_b_valid <= 1'b0;

            if (b_go && b_has_res) begin
                r_ov <= 1'b1;
                r_pv <= r_b_last_row;
            end else if (r_ov && i_m_axis_tready) begin
                if (r_pv)
                    r_pv <= 1'b0;
                else
                    r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_idx      <= r_idx;
            r_b_row      <= r_row;
            r_b_sample   <= i_s_axis_tdata[PIX_W-1:0];
            r_b_last_row <= last_row;
            r_b_interior <= interior;
        end
        if (b_go) begin
            r_hist[0] <= centre;
            for (int k = 1; k < MAX_CHANNELS; k++)
                r_hist[k] <= r_hist[k-1];
        end
        if (b_go && b_has_res) begin
            r_o <= res_first;
            r_p <= res_second;
        end else if (r_ov && i_m_axis_tready && r_pv) begin
            r_o <= r_p;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = r_o.last;
    assign o_m_axis_tdata  = {(OUT_DATA_W - PIX_W - IDX_OUT_W - ROW_OUT_W)'(0),
                              r_o.value, r_o.index, r_o.row};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sharp_pkg::*;

    // Design limits, same as the core's default parameters
    localparam int MAX_W  = 2048;
    localparam int MAX_CH = 4;
    localparam int MAX_H  = 4096;

    // Index 3 has no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Bit offsets of the result fields in m_axis tdata
    localparam int IDX_LSB = ROW_OUT_W;
    localparam int VAL_LSB = ROW_OUT_W + IDX_OUT_W;
    localparam int PAD_LSB = ROW_OUT_W + IDX_OUT_W + PIX_W;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the sharpened components from the accepted
    // samples and checks what the core sends back, oldest first.
    // ------------------------------------------------------------------
    class sharpen_scoreboard;
        logic [PIX_W-1:0]    older_row [MAX_W*MAX_CH];
        logic [PIX_W-1:0]    newer_row [MAX_W*MAX_CH];
        int                  row_pos;
        int                  comp_pos;
        logic [WIDTH_W-1:0]  cfg_width;
        logic [HEIGHT_W-1:0] cfg_height;
        logic [CH_W-1:0]     cfg_chan;
        t_result             expected_pix[$];
        int                  mismatches;
        int                  checked;
        int                  accepted;

        function new();
            cfg_width  = RST_WIDTH;
            cfg_height = RST_HEIGHT;
            cfg_chan   = RST_CHANNELS;
            row_pos    = 0;
            comp_pos   = 0;
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH:    cfg_width  = data[WIDTH_W-1:0];
                REG_HEIGHT:   cfg_height = data[HEIGHT_W-1:0];
                REG_CHANNELS: cfg_chan   = data[CH_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_int(input int v, input int lo, input int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int eff_width();
            return clamp_int(int'(cfg_width), 3, MAX_W);
        endfunction

        function int eff_height();
            return clamp_int(int'(cfg_height), 3, MAX_H);
        endfunction

        function int eff_chan();
            return clamp_int(int'(cfg_chan), 1, MAX_CH);
        endfunction

        function int frame_len();
            return eff_width() * eff_height() * eff_chan();
        endfunction

        function int pending();
            return expected_pix.size();
        endfunction

        // One accepted sample: queue the result for the row above (if any),
        // plus the zero border of the current row while in the last row.
        function void note_sample(input logic [PIX_W-1:0] s);
            int               w;
            int               h;
            int               c;
            int               i;
            int               r;
            int               t;
            bit               last_row;
            logic [PIX_W-1:0] val;
            t_result          res;
            w = eff_width();
            h = eff_height();
            c = eff_chan();
            i = comp_pos;
            r = row_pos;
            last_row = (r >= h - 1);
            accepted++;
            if (r >= 1) begin
                val = '0;
                // interior of the previous row only; borders stay zero
                if (r - 1 >= 1 && r - 1 <= h - 2 && i >= c && i < c * (w - 1)) begin
                    // left neighbour was already overwritten with row r-1
                    t = CENTRE_GAIN * int'(newer_row[i]) - int'(older_row[i - c])
                        - int'(newer_row[i + c]) - int'(older_row[i]) - int'(s);
                    if (t < 0)
                        val = '0;
                    else if (t > PIX_MAX)
                        val = PIX_W'(PIX_MAX);
                    else
                        val = PIX_W'(t);
                end
                res.row   = ROW_OUT_W'(r - 1);
                res.index = IDX_OUT_W'(i);
                res.value = val;
                res.last  = !last_row;
                expected_pix.push_back(res);
            end
            if (last_row) begin
                res.row   = ROW_OUT_W'(r);
                res.index = IDX_OUT_W'(i);
                res.value = '0;
                res.last  = 1'b1;
                expected_pix.push_back(res);
            end
            older_row[i] = newer_row[i];
            newer_row[i] = s;
            if (i >= w * c - 1) begin
                comp_pos = 0;
                row_pos  = last_row ? 0 : r + 1;
            end else begin
                comp_pos = i + 1;
            end
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
            t_result want;
            bit      bad;
            checked++;
            if (expected_pix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result row %0d idx %0d val %0d last %0b",
                             $realtime, data[ROW_OUT_W-1:0], data[IDX_LSB +: IDX_OUT_W],
                             data[VAL_LSB +: PIX_W], last);
                return;
            end
            want = expected_pix.pop_front();
            bad = (data[ROW_OUT_W-1:0] !== want.row)
               || (data[IDX_LSB +: IDX_OUT_W] !== want.index)
               || (data[VAL_LSB +: PIX_W] !== want.value)
               || (data[OUT_DATA_W-1:PAD_LSB] !== '0)
               || (last !== want.last);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp row %0d idx %0d val %0d last %0b",
                              " | got row %0d idx %0d val %0d last %0b pad %0h"},
                             $realtime, want.row, want.index, want.value, want.last,
                             data[ROW_OUT_W-1:0], data[IDX_LSB +: IDX_OUT_W],
                             data[VAL_LSB +: PIX_W], last, data[OUT_DATA_W-1:PAD_LSB]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata;    // [7:0] sample
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [11:0] out_row, [24:12] out_index, [32:25] value, [39:33] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;    // last_of_run

    sharpen_3x3_stencil_core #(
        .MAX_WIDTH    (MAX_W),
        .MAX_CHANNELS (MAX_CH),
        .MAX_HEIGHT   (MAX_H)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    sharpen_scoreboard sb;

    int send_idle_pct;   // chance (percent) the sender idles before a request
    int stall_pct;       // chance (percent) the receiver drops tready
    int hold_cycles;     // long receiver hold-off, counted down by the receiver
    int frames_run;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks every accepted result and decides tready for the
    // next cycle. Values are sampled at the edge before any NBA lands.
    // ------------------------------------------------------------------
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
            if (hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // Offer one sample, idling first at random; returns in the step of
    // acceptance with tvalid still high so back-to-back requests need no
    // second assignment in that step.
    task automatic send_sample(input logic [7:0] s);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_sample(s);
    endtask

    // Stop offering and wait until every expected result is back, then let
    // the pipeline registers settle before returning.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] c);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_CHANNELS, c);
    endtask

    // Biased toward the extremes so clamping hits both ends often
    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One whole frame at the current sizes; optionally the sender stops
    // halfway until the core has returned everything
    task automatic send_frame(input bit pause_midway);
        int n;
        n = sb.frame_len();
        for (int k = 0; k < n; k++) begin
            if (pause_midway && k == n / 2)
                drain();
            send_sample(rand_sample());
        end
        frames_run++;
    endtask

    // Random sizes, now and then out of range (clamped by the core), with
    // random bits above the width and channels registers (dropped by the core)
    task automatic random_config();
        int w;
        int h;
        int c;
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 7);
        c = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
        drain();
        write_reg(REG_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
        write_reg(REG_HEIGHT, 13'(h));
        write_reg(REG_CHANNELS, {10'($urandom), 3'(c)});
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_SPARE, 13'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int goal;
        bit first;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_cycles     = 0;
        frames_run      = 0;
        sb = new();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest frame, bright centre on black -> saturates high;
        // row 0 gives nothing, the last row gives a second zero result
        set_config(13'd3, 13'd3, 13'd1);
        for (int k = 0; k < 9; k++)
            send_sample(k == 4 ? 8'hFF : 8'h00);
        frames_run++;

        // Directed: registers changed mid-frame. Frame 4x6x1 stopped at row 3
        // index 3; shrinking to 3x3 makes that row beyond the last row and
        // that index beyond the row end, so the next sample closes the frame.
        set_config(13'd4, 13'd6, 13'd1);
        for (int k = 0; k < 15; k++)
            send_sample(8'(k * 17));
        drain();
        write_reg(REG_HEIGHT, 13'd3);
        write_reg(REG_WIDTH, 13'd3);
        send_sample(8'hA5);
        frames_run++;

        // Random frames under four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            goal  = sb.accepted + 412;
            first = 1'b1;
            while (sb.accepted < goal) begin
                if (first && ph == 0) begin
                    // receiver blocks for a long stretch while the sender
                    // keeps pushing: the core has to back-pressure its input
                    set_config(13'd12, 13'd6, 13'd4);
                    hold_cycles = 300;
                end else begin
                    random_config();
                end
                send_frame(first && ph == 1);
                first = 1'b0;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Summary: %0d samples in %0d frames, %0d results checked, %0d mismatches",
                 sb.accepted, frames_run, sb.checked, sb.mismatches);
        $display("Sizes 3x3x1 to 12x7x4 under idle and stall mixes; clamped, masked, mid-frame writes");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sharpen_3x3_stencil_core.f]
rtl/sharp_pkg.sv
rtl/sharp_cfg.sv
rtl/sharp_line.sv
rtl/sharp_calc.sv
rtl/sharpen_3x3_stencil_core.sv
tb/tb.sv
